// File: rtl/mfok_pkg.sv
package mfok_pkg;

  // Sine table geometry and angle scaling
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int ANGLE_BITS       = 16;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH);
  localparam int IDX_PROD_W       = 16 + IDX_W + 1;

  // Datapath widths
  localparam int TRIG_W  = 16;
  localparam int VXR_W   = 18;
  localparam int KWP_W   = 33;
  localparam int KW_W    = 25;
  localparam int WHEEL_W = 27;
  localparam int SCALE_W = 4;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int OUT_W   = 32;
  localparam int NUM_WHEELS = 4;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd5;

  // Register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATION_GAIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE  = 1'd1;

  // Saturation rails
  localparam logic signed [OUT_W-1:0] OUT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 32'sh8000_0000;

  // Frame angle mask for turns narrower than the field
  localparam logic [15:0] ANGLE_MASK = (ANGLE_BITS >= 16) ? 16'hFFFF :
                                       16'((32'd1 << ANGLE_BITS) - 32'd1);

  // Polynomial coefficients of sin(pi/2 * f), Q30
  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint PC1 = 64'sd1686629713;
  localparam longint PC3 = -64'sd693598669;
  localparam longint PC5 = 64'sd85569306;
  localparam longint PC7 = -64'sd5026994;
  localparam longint PC9 = 64'sd172272;

  typedef logic signed [TRIG_W-1:0] trig_tab_t [SINE_TABLE_DEPTH];

  // Stage enables of the rotation pipeline
  typedef struct packed {
    logic lookup;
    logic product;
    logic round;
  } rot_en_t;

  // Q30 product truncated toward zero
  function automatic longint mul_q30(longint a, longint unsigned f);
    logic neg;
    longint unsigned m;
    longint unsigned p;
    neg = (a < 0);
    m = neg ? longint'(-a) : longint'(a);
    p = (m * f) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // First quadrant sine, rounded to Q15 and clipped
  function automatic logic signed [TRIG_W-1:0] quarter_sine(longint unsigned f);
    longint unsigned f2;
    longint acc;
    longint s;
    longint unsigned q;
    f2  = (f * f) >> 30;
    acc = PC9;
    acc = PC7 + mul_q30(acc, f2);
    acc = PC5 + mul_q30(acc, f2);
    acc = PC3 + mul_q30(acc, f2);
    acc = PC1 + mul_q30(acc, f2);
    s   = mul_q30(acc, f);
    if (s <= 0) begin
      return '0;
    end
    q = (longint'(s) + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      return 16'sh7FFF;
    end
    return TRIG_W'(q);
  endfunction

  // Full turn sine of a Q32 phase through quadrant symmetry
  function automatic logic signed [TRIG_W-1:0] sine_of_phase(longint unsigned t);
    logic [1:0] quad;
    longint unsigned r;
    longint unsigned f;
    logic signed [TRIG_W-1:0] v;
    quad = 2'((t >> 30) & 64'd3);
    r    = t & (longint'(Q30_ONE) - 64'd1);
    f    = quad[0] ? (longint'(Q30_ONE) - r) : r;
    v    = quarter_sine(f);
    return quad[1] ? -v : v;
  endfunction

  function automatic trig_tab_t build_sin_tab();
    trig_tab_t tab;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      tab[i] = sine_of_phase((longint'(i) << 32) / SINE_TABLE_DEPTH);
    end
    return tab;
  endfunction

  function automatic trig_tab_t build_cos_tab();
    trig_tab_t tab;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      tab[i] = sine_of_phase(((longint'(i) << 32) / SINE_TABLE_DEPTH) + Q30_ONE);
    end
    return tab;
  endfunction

  localparam trig_tab_t SIN_TAB = build_sin_tab();
  localparam trig_tab_t COS_TAB = build_cos_tab();

endpackage

// File: rtl/mfok_cmd_if.sv
interface mfok_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] forward_speed;
  logic signed [15:0] lateral_speed;
  logic signed [15:0] yaw_rate;
  logic        [15:0] frame_angle;

  modport source (output valid, forward_speed, lateral_speed, yaw_rate, frame_angle,
                  input ready);
  modport sink   (input valid, forward_speed, lateral_speed, yaw_rate, frame_angle,
                  output ready);
endinterface

// File: rtl/mfok_res_if.sv
interface mfok_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wheel_front_left;
  logic signed [31:0] wheel_front_right;
  logic signed [31:0] wheel_rear_right;
  logic signed [31:0] wheel_rear_left;
  logic               saturated;

  modport source (output valid, wheel_front_left, wheel_front_right, wheel_rear_right,
                  wheel_rear_left, saturated, input ready);
  modport sink   (input valid, wheel_front_left, wheel_front_right, wheel_rear_right,
                  wheel_rear_left, saturated, output ready);
endinterface

// File: rtl/mfok_rotator.sv
module mfok_rotator import mfok_pkg::*; (
  input  logic                    clk,
  input  rot_en_t                 en,
  input  logic signed [15:0]      vx_in,
  input  logic signed [15:0]      vy_in,
  input  logic [IDX_W-1:0]        idx_in,
  output logic signed [VXR_W-1:0] vxr,
  output logic signed [VXR_W-1:0] vyr
);

  logic signed [15:0]       vx_l;
  logic signed [15:0]       vy_l;
  logic signed [TRIG_W-1:0] sin_l;
  logic signed [TRIG_W-1:0] cos_l;
  logic signed [31:0]       p_xc;
  logic signed [31:0]       p_ys;
  logic signed [31:0]       p_xs;
  logic signed [31:0]       p_yc;
  logic signed [32:0]       sum_x;
  logic signed [32:0]       sum_y;

  // Look up sine and cosine of the frame angle
  always_ff @(posedge clk) begin
    if (en.lookup) begin
      vx_l  <= vx_in;
      vy_l  <= vy_in;
      sin_l <= SIN_TAB[idx_in];
      cos_l <= COS_TAB[idx_in];
    end
  end

  // Form the four rotation products
  always_ff @(posedge clk) begin
    if (en.product) begin
      p_xc <= vx_l * cos_l;
      p_ys <= vy_l * sin_l;
      p_xs <= vx_l * sin_l;
      p_yc <= vy_l * cos_l;
    end
  end

  // Round half up to Q0; the top bits of the sum are the floor shift
  always_comb begin
    sum_x = 33'(p_xc) - 33'(p_ys) + 33'sd16384;
    sum_y = 33'(p_xs) + 33'(p_yc) + 33'sd16384;
  end

  always_ff @(posedge clk) begin
    if (en.round) begin
      vxr <= sum_x[32:15];
      vyr <= sum_y[32:15];
    end
  end

endmodule

// File: rtl/mecanum_field_oriented_kinematics.sv
// Channel  Dir  Payload
// -------  ---  -----------------------------------------------------------
// cmd      in   forward_speed, lateral_speed, yaw_rate (s16), frame_angle (u16)
// res      out  wheel_front_left/_front_right/_rear_right/_rear_left (s32),
//               saturated
// cfg_*    in   write port: cfg_we, cfg_index, cfg_data
//
// Six register stages: index, table lookup, products, rounding, wheel mix,
// scale and clip. One request enters per cycle while cmd.ready is high.
// Each stage holds its request while the next one is full and stalled, so a
// stalled result is kept and empty stages still fill behind it.
// Reset clears the valid bits and loads the register defaults.
module mecanum_field_oriented_kinematics import mfok_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  mfok_cmd_if.sink             cmd,
  mfok_res_if.source           res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int NSTAGE = 6;

  logic [GAIN_W-1:0]  rotation_gain;
  logic [SCALE_W-1:0] output_scale;

  logic [NSTAGE:1] v;
  logic [NSTAGE:1] en;

  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_PROD_W-1:0] idx_shift;

  logic signed [15:0]       vx1;
  logic signed [15:0]       vy1;
  logic signed [15:0]       w1;
  logic [IDX_W-1:0]         idx1;
  logic signed [KWP_W-1:0]  kwp2;
  logic signed [KW_W-1:0]   kw3;
  logic signed [KW_W-1:0]   kw4;
  logic signed [KWP_W-1:0]  kw_sum;
  logic signed [VXR_W-1:0]  vxr4;
  logic signed [VXR_W-1:0]  vyr4;
  logic signed [WHEEL_W-1:0] wheel5 [NUM_WHEELS];
  logic signed [WHEEL_W-1:0] wx;
  logic signed [WHEEL_W-1:0] wy;
  logic signed [WHEEL_W-1:0] wk;
  logic signed [OUT_W:0]     scaled [NUM_WHEELS];
  logic signed [OUT_W-1:0]   clip_val [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]     clip_hit;
  logic signed [OUT_W-1:0]   out_w [NUM_WHEELS];
  logic                      out_sat;
  rot_en_t                   rot_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_gain <= GAIN_RESET;
      output_scale  <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROTATION_GAIN: rotation_gain <= cfg_data[GAIN_W-1:0];
        REG_OUTPUT_SCALE:  output_scale  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NSTAGE] = !v[NSTAGE] || res.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign cmd.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= cmd.valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // Stage 1: table index from the frame angle
  always_comb begin
    idx_prod  = IDX_PROD_W'(cmd.frame_angle & ANGLE_MASK) *
                IDX_PROD_W'(SINE_TABLE_DEPTH);
    idx_shift = idx_prod >> ANGLE_BITS;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vx1  <= cmd.forward_speed;
      vy1  <= cmd.lateral_speed;
      w1   <= cmd.yaw_rate;
      idx1 <= idx_shift[IDX_W-1:0];
    end
  end

  // Stages 2 to 4: rotate the command into the chassis frame
  assign rot_en = '{lookup: en[2], product: en[3], round: en[4]};

  mfok_rotator u_rotator (
    .clk    (clk),
    .en     (rot_en),
    .vx_in  (vx1),
    .vy_in  (vy1),
    .idx_in (idx1),
    .vxr    (vxr4),
    .vyr    (vyr4)
  );

  // Yaw term alongside: multiply, round, then hold for the mix
  assign kw_sum = kwp2 + 33'sd128;

  always_ff @(posedge clk) begin
    if (en[2]) kwp2 <= KWP_W'(signed'({1'b0, rotation_gain})) * KWP_W'(w1);
    if (en[3]) kw3  <= kw_sum[KWP_W-1:8];
    if (en[4]) kw4  <= kw3;
  end

  // Stage 5: mecanum mix
  always_comb begin
    wx = WHEEL_W'(vxr4);
    wy = WHEEL_W'(vyr4);
    wk = WHEEL_W'(kw4);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      wheel5[0] <= wx - wy - wk;
      wheel5[1] <= -wx - wy - wk;
      wheel5[2] <= -wx + wy - wk;
      wheel5[3] <= wx + wy - wk;
    end
  end

  // Stage 6: scale and clip each wheel to the output rails
  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      scaled[i] = (OUT_W+1)'(wheel5[i]) * (OUT_W+1)'(signed'({1'b0, output_scale}));
      if (scaled[i] > (OUT_W+1)'(OUT_MAX)) begin
        clip_val[i] = OUT_MAX;
        clip_hit[i] = 1'b1;
      end else if (scaled[i] < (OUT_W+1)'(OUT_MIN)) begin
        clip_val[i] = OUT_MIN;
        clip_hit[i] = 1'b1;
      end else begin
        clip_val[i] = scaled[i][OUT_W-1:0];
        clip_hit[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        out_w[i] <= clip_val[i];
      end
      out_sat <= |clip_hit;
    end
  end

  assign res.valid             = v[NSTAGE];
  assign res.wheel_front_left  = out_w[0];
  assign res.wheel_front_right = out_w[1];
  assign res.wheel_rear_right  = out_w[2];
  assign res.wheel_rear_left   = out_w[3];
  assign res.saturated         = out_sat;

  // A clipped result always sits on a rail
  a_sat_on_rail: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.saturated |->
      (out_w[0] == OUT_MAX || out_w[0] == OUT_MIN || out_w[1] == OUT_MAX ||
       out_w[1] == OUT_MIN || out_w[2] == OUT_MAX || out_w[2] == OUT_MIN ||
       out_w[3] == OUT_MAX || out_w[3] == OUT_MIN))
    else $error("saturated flag without a clipped wheel");

  // A full pipeline behind a stalled result takes no new request
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&v) && !res.ready |-> !cmd.ready)
    else $error("request accepted into a full, stalled pipeline");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res.valid && v == '0)
    else $error("valid bit survived reset");

endmodule

// File: bench/tb.sv
import mfok_pkg::*;

typedef longint unsigned u64_t;

typedef struct {
  logic signed [15:0] forward_speed;
  logic signed [15:0] lateral_speed;
  logic signed [15:0] yaw_rate;
  logic        [15:0] frame_angle;
} speed_cmd_t;

typedef struct {
  logic signed [31:0] front_left;
  logic signed [31:0] front_right;
  logic signed [31:0] rear_right;
  logic signed [31:0] rear_left;
  logic               saturated;
} wheel_set_t;

class wheel_target_board;
  int                 sine_q15 [SINE_TABLE_DEPTH];
  int                 cosine_q15 [SINE_TABLE_DEPTH];
  logic [GAIN_W-1:0]  gain;
  logic [SCALE_W-1:0] scale;
  wheel_set_t         pending_targets [$];
  int unsigned        faults;
  int unsigned        shown;

  function new();
    u64_t phase;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      phase         = (u64_t'(i) << 32) / SINE_TABLE_DEPTH;
      sine_q15[i]   = turn_sine(phase);
      cosine_q15[i] = turn_sine(phase + (u64_t'(1) << 30));
    end
    gain   = 16'd256;
    scale  = 4'd5;
    faults = 0;
    shown  = 0;
  endfunction

  // Q30 product, truncated toward zero
  function longint trunc_q30(longint a, u64_t f);
    u64_t mag;
    mag = (a < 0) ? u64_t'(-a) : u64_t'(a);
    mag = (mag * f) >> 30;
    return (a < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // sin(pi/2 * f) for f in [0, 1] Q30, rounded to Q15 and clipped
  function int quarter_wave(u64_t f);
    u64_t   f2;
    longint acc;
    longint q;
    f2  = (f * f) >> 30;
    acc = 172272;
    acc = -5026994 + trunc_q30(acc, f2);
    acc = 85569306 + trunc_q30(acc, f2);
    acc = -693598669 + trunc_q30(acc, f2);
    acc = 1686629713 + trunc_q30(acc, f2);
    acc = trunc_q30(acc, f);
    if (acc <= 0) return 0;
    q = (acc + 16384) >>> 15;
    return (q > 32767) ? 32767 : int'(q);
  endfunction

  // Full turn from the first quadrant; phase is Q32 of a turn
  function int turn_sine(u64_t phase);
    logic [1:0] quad;
    u64_t       frac;
    int         mag;
    quad = phase[31:30];
    frac = phase & ((u64_t'(1) << 30) - 1);
    if (quad[0]) frac = (u64_t'(1) << 30) - frac;
    mag = quarter_wave(frac);
    return quad[1] ? -mag : mag;
  endfunction

  // Keep only the bits each register holds
  function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
    if (index == REG_ROTATION_GAIN) gain = data[GAIN_W-1:0];
    else if (index == REG_OUTPUT_SCALE) scale = data[SCALE_W-1:0];
  endfunction

  // Rotate the command into the chassis frame, mix, scale and clip
  function wheel_set_t wheel_targets(speed_cmd_t c);
    wheel_set_t t;
    u64_t       angle;
    u64_t       idx;
    longint     vx, vy, w, sn, cs, vxr, vyr, kw, v;
    longint     mix [4];
    logic signed [31:0] clipped [4];
    vx    = longint'(c.forward_speed);
    vy    = longint'(c.lateral_speed);
    w     = longint'(c.yaw_rate);
    angle = u64_t'(c.frame_angle) & ((u64_t'(1) << ANGLE_BITS) - 1);
    idx   = ((angle * SINE_TABLE_DEPTH) >> ANGLE_BITS) % SINE_TABLE_DEPTH;
    sn    = longint'(sine_q15[idx]);
    cs    = longint'(cosine_q15[idx]);
    vxr   = (vx * cs - vy * sn + 16384) >>> 15;
    vyr   = (vx * sn + vy * cs + 16384) >>> 15;
    kw    = (longint'(gain) * w + 128) >>> 8;
    mix[0] = vxr - vyr - kw;
    mix[1] = -vxr - vyr - kw;
    mix[2] = -vxr + vyr - kw;
    mix[3] = vxr + vyr - kw;
    t.saturated = 1'b0;
    for (int i = 0; i < 4; i++) begin
      v = mix[i] * longint'(scale);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        t.saturated = 1'b1;
      end
      if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        t.saturated = 1'b1;
      end
      clipped[i] = v[31:0];
    end
    t.front_left  = clipped[0];
    t.front_right = clipped[1];
    t.rear_right  = clipped[2];
    t.rear_left   = clipped[3];
    return t;
  endfunction

  function void note_command(speed_cmd_t c);
    pending_targets.push_back(wheel_targets(c));
  endfunction

  // Compare a result with the oldest outstanding request
  function void check_result(wheel_set_t got);
    wheel_set_t  want;
    logic [31:0] e [5];
    logic [31:0] a [5];
    string       names [5];
    if (pending_targets.size() == 0) begin
      faults++;
      if (shown < 10) begin
        shown++;
        $display("result with no request outstanding: %0d %0d %0d %0d sat %0d",
                 got.front_left, got.front_right, got.rear_right, got.rear_left,
                 got.saturated);
      end
      return;
    end
    want  = pending_targets.pop_front();
    names = '{"wheel_front_left", "wheel_front_right", "wheel_rear_right",
              "wheel_rear_left", "saturated"};
    e = '{want.front_left, want.front_right, want.rear_right, want.rear_left,
          {31'd0, want.saturated}};
    a = '{got.front_left, got.front_right, got.rear_right, got.rear_left,
          {31'd0, got.saturated}};
    for (int i = 0; i < 5; i++) begin
      if (a[i] !== e[i]) begin
        faults++;
        if (shown < 10) begin
          shown++;
          $display("%s mismatch: expected %0d, got %0d", names[i],
                   $signed(e[i]), $signed(a[i]));
        end
      end
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  mfok_cmd_if cmd_bus ();
  mfok_res_if res_bus ();

  mecanum_field_oriented_kinematics dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_bus),
    .res       (res_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wheel_target_board board;
  bit                steady;
  bit                hold_off_request;
  bit                hold_taken;
  int                hold_left;
  logic [15:0]       gain_plan [5];
  logic [15:0]       scale_plan [5];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Limit the run
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit idle_roll();
    return !steady && ($urandom_range(99) < 34);
  endfunction

  // Favour extremes now and then, otherwise any value
  function automatic logic [15:0] pick_field();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return ($urandom_range(1) != 0) ? 16'h0000 : 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one request, with optional idle gaps first; returns at a falling edge
  task automatic send_command(input logic [15:0] vx, input logic [15:0] vy,
                              input logic [15:0] w, input logic [15:0] angle);
    while (idle_roll()) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid         <= 1'b1;
    cmd_bus.forward_speed <= vx;
    cmd_bus.lateral_speed <= vy;
    cmd_bus.yaw_rate      <= w;
    cmd_bus.frame_angle   <= angle;
    do @(posedge clk); while (!cmd_bus.ready);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    board.set_register(index, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Drop valid and wait until every request has come back, then a little longer
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    while (board.pending_targets.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request
  initial begin
    res_bus.ready = 1'b0;
    hold_left     = 0;
    hold_taken    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 48;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= !idle_roll();
      end
    end
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    speed_cmd_t req;
    wheel_set_t seen;
    if (!rst) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        req.forward_speed = cmd_bus.forward_speed;
        req.lateral_speed = cmd_bus.lateral_speed;
        req.yaw_rate      = cmd_bus.yaw_rate;
        req.frame_angle   = cmd_bus.frame_angle;
        board.note_command(req);
      end
      if (res_bus.valid && res_bus.ready) begin
        seen.front_left  = res_bus.wheel_front_left;
        seen.front_right = res_bus.wheel_front_right;
        seen.rear_right  = res_bus.wheel_rear_right;
        seen.rear_left   = res_bus.wheel_rear_left;
        seen.saturated   = res_bus.saturated;
        board.check_result(seen);
      end
    end
  end

  initial begin
    board                 = new();
    steady                = 1'b0;
    hold_off_request      = 1'b0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_ROTATION_GAIN;
    cfg_data              = '0;
    cmd_bus.valid         = 1'b0;
    cmd_bus.forward_speed = '0;
    cmd_bus.lateral_speed = '0;
    cmd_bus.yaw_rate      = '0;
    cmd_bus.frame_angle   = '0;
    // Gain 0 with scale 0 under junk upper bits, both maxima, both ones, then random
    gain_plan  = '{16'h0000, 16'hFFFF, 16'h0001, 16'($urandom), 16'($urandom)};
    scale_plan = '{16'hFFF0, 16'h000F, 16'h0001, 16'($urandom), 16'($urandom)};

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at the reset register values
    send_command(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send_command(16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
    send_command(16'h0000, 16'h8000, 16'h0000, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'h8000, 16'h0000);
    // Rounding of the yaw term either side of zero, then combined extremes
    send_command(16'h0000, 16'h0000, 16'h0001, 16'h0000);
    send_command(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_command(16'h8000, 16'h8000, 16'h8000, 16'h2000);
    send_command(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    // Quadrant points and table index boundaries
    send_command(16'd1000, -16'sd2000, 16'd300, 16'h4000);
    send_command(16'd1000, -16'sd2000, 16'd300, 16'h8000);
    send_command(16'd1000, -16'sd2000, 16'd300, 16'hC000);
    send_command(16'd1000, -16'sd2000, 16'd300, 16'h00FF);
    send_command(16'd1000, -16'sd2000, 16'd300, 16'h0100);
    send_command(16'h8000, 16'h7FFF, 16'hFFFF, 16'h3FFF);
    send_command(16'h0001, 16'h0001, 16'h0000, 16'h2000);
    settle();

    // Random requests under each register setting
    for (int p = 0; p < 5; p++) begin
      write_register(REG_ROTATION_GAIN, gain_plan[p]);
      write_register(REG_OUTPUT_SCALE, scale_plan[p]);
      for (int n = 0; n < 80; n++) begin
        // Hold the receiver off while the sender streams, so the pipe fills
        if (p == 2 && n == 0) begin
          steady           = 1'b1;
          hold_off_request = 1'b1;
        end
        if (p == 2 && n == 60) steady = 1'b0;
        send_command(pick_field(), pick_field(), pick_field(), pick_field());
      end
      settle();
    end

    if (board.faults == 0 && board.pending_targets.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
